// File: sv/vp9rtp_pkg.sv
// ----------------------------------------------------------------------------
// vp9rtp_pkg: shared types and constants for the VP9 RTP descriptor parser
// Holds the parse phase encoding, flag bit positions and counter widths.
// ----------------------------------------------------------------------------
package vp9rtp_pkg;

   // byte counter width and its saturation value
   localparam int POS_BITS = 16;
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   // width of the reported offset and length fields
   localparam int LEN_BITS = 16;

   // bit positions inside the stored flag byte (flag byte shifted right by one)
   localparam int FL_I = 6;
   localparam int FL_P = 5;
   localparam int FL_L = 4;
   localparam int FL_F = 3;
   localparam int FL_B = 2;
   localparam int FL_E = 1;
   localparam int FL_V = 0;

   // bit positions of the scalability structure bits (Y, G)
   localparam int SB_Y = 1;
   localparam int SB_G = 0;

   // descriptor walk phases
   typedef enum logic [3:0] {
      PH_FLAG    = 4'd0,
      PH_PID1    = 4'd1,
      PH_PID2    = 4'd2,
      PH_LAYER   = 4'd3,
      PH_REF     = 4'd4,
      PH_SS      = 4'd5,
      PH_DIMS    = 4'd6,
      PH_NG      = 4'd7,
      PH_PG      = 4'd8,
      PH_PDIFF   = 4'd9,
      PH_PAYLOAD = 4'd10
   } phase_type;

endpackage

// File: sv/vp9_rtp_descriptor_parser.sv
// ----------------------------------------------------------------------------
// vp9_rtp_descriptor_parser: VP9 RTP payload descriptor parser
// Walks the descriptor one payload byte per item and reports the flags,
// picture ID, payload offset and payload length at the last byte.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | data_byte, last_byte
//  rsp     | out       | rsp_valid/rsp_ready | parse_ok, flags, picture_number,
//          |           |                     | payload_offset, payload_length
//
//  One byte is taken per cycle while req_ready is high; the walk state updates in the cycle of
//  acceptance and a last byte loads the result register, seen in the next cycle.
//  Synchronous reset clears the walk state and the result valid.
//  Bytes that are not last are taken even while a result waits; a last byte
//  waits only while the result register is full and not being taken.
// ----------------------------------------------------------------------------
module vp9_rtp_descriptor_parser
   import vp9rtp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_parse_ok,
   output logic                rsp_pic_id_flag,
   output logic                rsp_inter_flag,
   output logic                rsp_frame_begin,
   output logic                rsp_frame_end,
   output logic [14:0]         rsp_picture_number,
   output logic [LEN_BITS-1:0] rsp_payload_offset,
   output logic [LEN_BITS-1:0] rsp_payload_length
);

   // walk state
   phase_type           phase_ff, phase_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [6:0]          flags_ff, flags_in;
   logic [14:0]         pic_ff, pic_in;
   logic [5:0]          skip_ff, skip_in;
   logic [7:0]          grp_ff, grp_in;
   logic [1:0]          ref_ff, ref_in;
   logic [1:0]          sb_ff, sb_in;
   logic [POS_BITS-1:0] hend_ff, hend_in;

   // result register
   logic                rsp_valid_ff;
   logic                ok_ff, ok_in;
   logic [6:0]          rflags_ff;
   logic [14:0]         rpic_ff, rpic_in;
   logic [LEN_BITS-1:0] roff_ff, roff_in;
   logic [LEN_BITS-1:0] rlen_ff, rlen_in;

   logic                accept;
   logic                go_pic, go_layer, go_refs, go_dims, go_next, go_fin;
   logic [7:0]          grp_dec;
   logic [POS_BITS-1:0] len_full;

   // byte may enter unless it would overwrite a waiting result
   assign req_ready = !rsp_valid_ff || rsp_ready || !req_last_byte;
   assign accept    = req_valid && req_ready;

   // next walk state for the byte on the input
   always_comb begin
      phase_in = phase_ff;
      pos_in   = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
      flags_in = flags_ff;
      pic_in   = pic_ff;
      skip_in  = skip_ff;
      grp_in   = grp_ff;
      ref_in   = ref_ff;
      sb_in    = sb_ff;
      hend_in  = hend_ff;
      go_pic   = 1'b0;
      go_layer = 1'b0;
      go_refs  = 1'b0;
      go_dims  = 1'b0;
      go_next  = 1'b0;
      go_fin   = 1'b0;
      grp_dec  = (grp_ff != 8'd0) ? grp_ff - 8'd1 : grp_ff;

      case (phase_ff)
         PH_PID1: begin
            if (req_data_byte[7]) begin
               pic_in   = {req_data_byte[6:0], 8'd0};
               phase_in = PH_PID2;
            end else begin
               pic_in = {8'd0, req_data_byte[6:0]};
               go_pic = 1'b1;
            end
         end
         PH_PID2: begin
            pic_in = {pic_ff[14:8], req_data_byte};
            go_pic = 1'b1;
         end
         PH_LAYER, PH_DIMS: begin
            skip_in = (skip_ff != 6'd0) ? skip_ff - 6'd1 : skip_ff;
            if (skip_in == 6'd0) begin
               go_layer = (phase_ff == PH_LAYER);
               go_dims  = (phase_ff == PH_DIMS);
            end
         end
         PH_REF: begin
            ref_in = ref_ff + 2'd1;
            if (!req_data_byte[0] || ref_in == 2'd3) begin
               go_refs = 1'b1;
            end
         end
         PH_SS: begin
            sb_in = {req_data_byte[4], req_data_byte[3]};
            if (sb_in[SB_Y]) begin
               skip_in  = {({1'b0, req_data_byte[7:5]} + 4'd1), 2'b00};
               phase_in = PH_DIMS;
            end else begin
               go_dims = 1'b1;
            end
         end
         PH_NG: begin
            if (req_data_byte != 8'd0) begin
               grp_in   = req_data_byte;
               phase_in = PH_PG;
            end else begin
               go_fin = 1'b1;
            end
         end
         PH_PG: begin
            skip_in = {4'd0, req_data_byte[3:2]};
            if (skip_in != 6'd0) begin
               phase_in = PH_PDIFF;
            end else begin
               go_next = 1'b1;
            end
         end
         PH_PDIFF: begin
            skip_in = (skip_ff != 6'd0) ? skip_ff - 6'd1 : skip_ff;
            if (skip_in == 6'd0) begin
               go_next = 1'b1;
            end
         end
         PH_PAYLOAD: begin
         end
         default: begin
            // flag byte, also taken for unused phase codes
            flags_in = req_data_byte[7:1];
            pic_in   = 15'd0;
            if (flags_in[FL_I]) begin
               phase_in = PH_PID1;
            end else begin
               go_pic = 1'b1;
            end
         end
      endcase

      // follow-on steps once a descriptor section ends
      if (go_pic) begin
         if (flags_in[FL_L]) begin
            phase_in = PH_LAYER;
            skip_in  = flags_in[FL_F] ? 6'd1 : 6'd2;
         end else begin
            go_layer = 1'b1;
         end
      end
      if (go_layer) begin
         if (flags_in[FL_F] && flags_in[FL_P]) begin
            phase_in = PH_REF;
            ref_in   = 2'd0;
         end else begin
            go_refs = 1'b1;
         end
      end
      if (go_refs) begin
         if (flags_in[FL_V]) begin
            phase_in = PH_SS;
         end else begin
            go_fin = 1'b1;
         end
      end
      if (go_dims) begin
         if (sb_in[SB_G]) begin
            phase_in = PH_NG;
         end else begin
            go_fin = 1'b1;
         end
      end
      if (go_next) begin
         grp_in = grp_dec;
         if (grp_dec != 8'd0) begin
            phase_in = PH_PG;
         end else begin
            go_fin = 1'b1;
         end
      end
      if (go_fin) begin
         phase_in = PH_PAYLOAD;
         hend_in  = pos_in;
      end
   end

   // result fields for a last byte
   always_comb begin
      ok_in    = (phase_in == PH_PAYLOAD);
      len_full = (ok_in && pos_in >= hend_in) ? pos_in - hend_in : '0;
      rpic_in  = ok_in ? pic_in : 15'd0;
      roff_in  = ok_in ? LEN_BITS'(hend_in) : '0;
      rlen_in  = LEN_BITS'(len_full);
   end

   // walk state registers, cleared after each packet
   always_ff @(posedge clock) begin
      if (reset || (accept && req_last_byte)) begin
         phase_ff <= PH_FLAG;
         pos_ff   <= '0;
         flags_ff <= 7'd0;
         pic_ff   <= 15'd0;
         skip_ff  <= 6'd0;
         grp_ff   <= 8'd0;
         ref_ff   <= 2'd0;
         sb_ff    <= 2'd0;
         hend_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         flags_ff <= flags_in;
         pic_ff   <= pic_in;
         skip_ff  <= skip_in;
         grp_ff   <= grp_in;
         ref_ff   <= ref_in;
         sb_ff    <= sb_in;
         hend_ff  <= hend_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept && req_last_byte) begin
         ok_ff     <= ok_in;
         rflags_ff <= flags_in;
         rpic_ff   <= rpic_in;
         roff_ff   <= roff_in;
         rlen_ff   <= rlen_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_parse_ok       = ok_ff;
   assign rsp_pic_id_flag    = rflags_ff[FL_I];
   assign rsp_inter_flag     = rflags_ff[FL_P];
   assign rsp_frame_begin    = rflags_ff[FL_B];
   assign rsp_frame_end      = rflags_ff[FL_E];
   assign rsp_picture_number = rpic_ff;
   assign rsp_payload_offset = roff_ff;
   assign rsp_payload_length = rlen_ff;

`ifndef SYNTHESIS
   // a last byte always returns the walk to the flag byte
   a_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> phase_ff == PH_FLAG && pos_ff == '0)
      else $error("walk not restarted after last byte");

   // truncated packets report zero picture, offset and length
   a_trunc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !ok_ff |-> rpic_ff == 15'd0 && roff_ff == '0 && rlen_ff == '0)
      else $error("truncated result carries nonzero fields");

   // skip phases never sit with an empty skip count
   a_skip_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LAYER || phase_ff == PH_DIMS || phase_ff == PH_PDIFF)
      |-> skip_ff != 6'd0)
      else $error("skip phase with zero count");

   // picture-group phase always has entries left
   a_group_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PG |-> grp_ff != 8'd0)
      else $error("group phase with no entries left");

   // input stalls only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff && !rsp_ready && req_last_byte)
      else $error("input stalled without a waiting result");
`endif

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for vp9_rtp_descriptor_parser
// Sends RTP payload bytes with random gaps and receiver stalls, tracks the
// descriptor walk in a local predictor and checks every reported result
// field by field against the predicted one.
// ----------------------------------------------------------------------------
module tb;
   import vp9rtp_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_ITEMS = 1000;

   typedef struct {
      logic [7:0] data;
      logic       last;
      int         gap;
   } byte_item_type;

   typedef struct {
      logic                ok;
      logic                id_present;
      logic                inter;
      logic                sof;
      logic                eof;
      logic [14:0]         picture;
      logic [LEN_BITS-1:0] offset;
      logic [LEN_BITS-1:0] length;
   } descriptor_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_data_byte = 8'h00;
   logic                req_last_byte = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_parse_ok;
   logic                rsp_pic_id_flag;
   logic                rsp_inter_flag;
   logic                rsp_frame_begin;
   logic                rsp_frame_end;
   logic [14:0]         rsp_picture_number;
   logic [LEN_BITS-1:0] rsp_payload_offset;
   logic [LEN_BITS-1:0] rsp_payload_length;

   byte_item_type         byte_queue[$];
   descriptor_result_type pending_results[$];
   byte_item_type         next_byte;
   descriptor_result_type predicted;
   descriptor_result_type expected_result;

   int  cycle_count = 0;
   int  failures = 0;
   int  items_queued = 0;
   int  gap_left = 0;
   bit  gap_loaded = 0;
   int  rsp_wait = 0;
   int  hold_left = 0;
   bit  rsp_quiet = 0;
   bit  sender_quiet = 0;
   bit  hold_off_request = 0;
   bit  req_taken = 0;
   bit  rsp_taken = 0;

   // predictor state of the descriptor walk
   phase_type        walk_phase;
   logic [POS_BITS-1:0] bytes_seen;
   logic [6:0]       flag_bits;
   logic [14:0]      pic_id;
   int unsigned      skip_left;
   int unsigned      groups_left;
   logic [1:0]       refs_read;
   logic [1:0]       ss_bits;
   logic [POS_BITS-1:0] desc_end;

   vp9_rtp_descriptor_parser DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_parse_ok       (rsp_parse_ok),
      .rsp_pic_id_flag    (rsp_pic_id_flag),
      .rsp_inter_flag     (rsp_inter_flag),
      .rsp_frame_begin    (rsp_frame_begin),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_picture_number (rsp_picture_number),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_payload_length (rsp_payload_length)
   );

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // descriptor walk predictor
   // ------------------------------------------------------------------------
   function automatic void clear_walk();
      walk_phase  = PH_FLAG;
      bytes_seen  = '0;
      flag_bits   = '0;
      pic_id      = '0;
      skip_left   = 0;
      groups_left = 0;
      refs_read   = '0;
      ss_bits     = '0;
      desc_end    = '0;
   endfunction

   function automatic void finish_descriptor();
      walk_phase = PH_PAYLOAD;
      desc_end   = bytes_seen;
   endfunction

   function automatic void after_dimensions();
      if (ss_bits[SB_G]) begin
         walk_phase = PH_NG;
      end else begin
         finish_descriptor();
      end
   endfunction

   function automatic void after_references();
      if (flag_bits[FL_V]) begin
         walk_phase = PH_SS;
      end else begin
         finish_descriptor();
      end
   endfunction

   function automatic void after_layers();
      if (flag_bits[FL_F] && flag_bits[FL_P]) begin
         walk_phase = PH_REF;
         refs_read  = '0;
      end else begin
         after_references();
      end
   endfunction

   function automatic void after_picture_id();
      if (flag_bits[FL_L]) begin
         walk_phase = PH_LAYER;
         skip_left  = flag_bits[FL_F] ? 1 : 2;
      end else begin
         after_layers();
      end
   endfunction

   function automatic void next_picture_group();
      if (groups_left > 0) groups_left--;
      if (groups_left > 0) begin
         walk_phase = PH_PG;
      end else begin
         finish_descriptor();
      end
   endfunction

   // advance the walk by one byte; returns 1 when the byte closes a packet
   function automatic bit walk_byte(input logic [7:0] b, input logic last,
                                    output descriptor_result_type res);
      logic ok;
      res = '{default: '0};
      if (bytes_seen != POS_MAX) bytes_seen++;
      case (walk_phase)
         PH_PID1: begin
            if (b[7]) begin
               pic_id     = {b[6:0], 8'h00};
               walk_phase = PH_PID2;
            end else begin
               pic_id = {8'h00, b[6:0]};
               after_picture_id();
            end
         end
         PH_PID2: begin
            pic_id = pic_id | 15'(b);
            after_picture_id();
         end
         PH_LAYER: begin
            if (skip_left > 0) skip_left--;
            if (skip_left == 0) after_layers();
         end
         PH_REF: begin
            refs_read = refs_read + 2'd1;
            if (!b[0] || refs_read == 2'd3) after_references();
         end
         PH_SS: begin
            ss_bits = {b[4], b[3]};
            if (ss_bits[SB_Y]) begin
               skip_left  = (int'(b[7:5]) + 1) * 4;
               walk_phase = PH_DIMS;
            end else begin
               after_dimensions();
            end
         end
         PH_DIMS: begin
            if (skip_left > 0) skip_left--;
            if (skip_left == 0) after_dimensions();
         end
         PH_NG: begin
            if (b != 8'h00) begin
               groups_left = 32'(b);
               walk_phase  = PH_PG;
            end else begin
               finish_descriptor();
            end
         end
         PH_PG: begin
            skip_left = 32'(b[3:2]);
            if (skip_left != 0) begin
               walk_phase = PH_PDIFF;
            end else begin
               next_picture_group();
            end
         end
         PH_PDIFF: begin
            if (skip_left > 0) skip_left--;
            if (skip_left == 0) next_picture_group();
         end
         PH_PAYLOAD: begin
         end
         default: begin
            // flag byte
            flag_bits = b[7:1];
            pic_id    = '0;
            if (flag_bits[FL_I]) begin
               walk_phase = PH_PID1;
            end else begin
               after_picture_id();
            end
         end
      endcase
      if (!last) return 0;
      ok             = (walk_phase == PH_PAYLOAD);
      res.ok         = ok;
      res.id_present = flag_bits[FL_I];
      res.inter      = flag_bits[FL_P];
      res.sof        = flag_bits[FL_B];
      res.eof        = flag_bits[FL_E];
      res.picture    = ok ? pic_id : '0;
      res.offset     = ok ? LEN_BITS'(desc_end) : '0;
      res.length     = (ok && bytes_seen >= desc_end) ? LEN_BITS'(bytes_seen - desc_end) : '0;
      clear_walk();
      return 1;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus builders
   // ------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] data, input logic last);
      byte_item_type item;
      item.data = data;
      item.last = last;
      item.gap  = sender_quiet ? 0 : $urandom_range(0, 4);
      byte_queue.push_back(item);
      items_queued++;
   endtask

   // well-formed descriptor with random content; cut >= 0 keeps at most cut+1 bytes
   task automatic make_packet(input logic [7:0] flags, input logic [7:0] ss,
                              input int groups, input int payload, input int cut);
      logic [7:0] bytes_out[$];
      logic [7:0] b;
      int         refs;
      int         total;
      int         i;
      bytes_out.push_back(flags);
      // flag byte holds the stored flag bits one place up
      if (flags[FL_I+1]) begin
         if ($urandom_range(0, 1)) begin
            bytes_out.push_back(8'($urandom_range(128, 255)));
            bytes_out.push_back(8'($urandom));
         end else begin
            bytes_out.push_back(8'($urandom_range(0, 127)));
         end
      end
      if (flags[FL_L+1]) begin
         repeat (flags[FL_F+1] ? 1 : 2) bytes_out.push_back(8'($urandom));
      end
      // flexible-mode references, continuation in bit 0
      if (flags[FL_F+1] && flags[FL_P+1]) begin
         refs = $urandom_range(1, 3);
         for (i = 1; i <= refs; i++) begin
            b = 8'($urandom);
            if (i < refs) b[0] = 1'b1;
            else if (i < 3) b[0] = 1'b0;
            bytes_out.push_back(b);
         end
      end
      // scalability structure
      if (flags[FL_V+1]) begin
         bytes_out.push_back(ss);
         if (ss[4]) begin
            repeat ((int'(ss[7:5]) + 1) * 4) bytes_out.push_back(8'($urandom));
         end
         if (ss[3]) begin
            bytes_out.push_back(8'(groups));
            repeat (groups) begin
               b = 8'($urandom);
               bytes_out.push_back(b);
               repeat (int'(b[3:2])) bytes_out.push_back(8'($urandom));
            end
         end
      end
      repeat (payload) bytes_out.push_back(8'($urandom));
      total = bytes_out.size();
      if (cut >= 0 && cut < total - 1) total = cut + 1;
      for (i = 0; i < total; i++) push_byte(bytes_out[i], i == total - 1);
   endtask

   task automatic drain();
      while (byte_queue.size() != 0 || req_valid || pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // ------------------------------------------------------------------------
   // driver: offers bytes at the falling edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (byte_queue.size() != 0 && !gap_loaded) begin
            gap_left   = byte_queue[0].gap;
            gap_loaded = 1;
         end
         if (byte_queue.size() != 0 && gap_left == 0) begin
            next_byte = byte_queue.pop_front();
            gap_loaded = 0;
            req_valid <= 1'b1;
            req_data_byte <= next_byte.data;
            req_last_byte <= next_byte.last;
         end else begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end
      end
   end

   // receiver: random stalls per item, plus one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_off_request) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_request = 0;
         end
         if (rsp_taken) begin
            if ($urandom_range(0, 7) == 0) rsp_quiet = !rsp_quiet;
            rsp_wait = rsp_quiet ? 0 : $urandom_range(0, 4);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: checks results and predicts at the rising edge
   always @(posedge clock) begin
      cycle_count++;
      if (reset) begin
         req_taken = 0;
         rsp_taken = 0;
      end else begin
         rsp_taken = rsp_valid && rsp_ready;
         if (rsp_taken) begin
            if (pending_results.size() == 0) begin
               $error("result item with no expectation waiting");
               failures++;
            end else begin
               expected_result = pending_results.pop_front();
               check_field("parse_ok", expected_result.ok, rsp_parse_ok);
               check_field("pic_id_flag", expected_result.id_present, rsp_pic_id_flag);
               check_field("inter_flag", expected_result.inter, rsp_inter_flag);
               check_field("frame_begin", expected_result.sof, rsp_frame_begin);
               check_field("frame_end", expected_result.eof, rsp_frame_end);
               check_field("picture_number", expected_result.picture, rsp_picture_number);
               check_field("payload_offset", expected_result.offset, rsp_payload_offset);
               check_field("payload_length", expected_result.length, rsp_payload_length);
            end
         end
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            if (walk_byte(req_data_byte, req_last_byte, predicted))
               pending_results.push_back(predicted);
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      int kind;
      int len;
      clear_walk();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty payload, reserved bit, picture id extremes
      make_packet(8'h00, 8'h00, 0, 0, -1);
      make_packet(8'h01, 8'h00, 0, 3, -1);
      push_byte(8'h80, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b1);
      push_byte(8'h80, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h00, 1'b1);
      // all flags with the largest scalability structure
      make_packet(8'hFE, 8'hF8, 255, 2, -1);
      // flexible references, layer bytes in both modes
      make_packet(8'hD0, 8'h00, 0, 1, -1);
      make_packet(8'hA0, 8'h00, 0, 1, -1);
      make_packet(8'h30, 8'h00, 0, 0, -1);
      // structure without sizes, with sizes only, with zero groups
      make_packet(8'h02, 8'h00, 0, 0, -1);
      make_packet(8'h02, 8'h10, 0, 1, -1);
      make_packet(8'h02, 8'h08, 0, 2, -1);
      // truncated packets
      make_packet(8'h80, 8'h00, 0, 0, 0);
      make_packet(8'hFE, 8'hF8, 3, 0, 5);
      make_packet(8'h50, 8'h00, 0, 0, 0);
      drain();

      // receiver holds off while short packets keep coming
      hold_off_request = 1;
      repeat (16) make_packet(8'h00, 8'h00, 0, $urandom_range(0, 3), -1);
      drain();

      // random part: mostly well-formed descriptors, some truncation and noise
      while (items_queued < RANDOM_ITEMS + 40) begin
         sender_quiet = ($urandom_range(0, 4) == 0);
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) push_byte(8'($urandom), i == len - 1);
         end else begin
            make_packet(8'($urandom), 8'($urandom),
                        ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 3),
                        $urandom_range(0, 6),
                        (kind == 1) ? $urandom_range(0, 8) : -1);
         end
      end
      drain();

      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
